[rtl/arc_odometry_pose_update_unit_assert.svh]
// assertion macros used by the arc odometry top level
`ifndef ARC_ODOMETRY_POSE_UPDATE_UNIT_ASSERT_SVH
`define ARC_ODOMETRY_POSE_UPDATE_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define AOPU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aopu assertion failed");

// condition holds in the cycle after the trigger
`define AOPU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aopu assertion failed");

`endif

[rtl/aopu_pkg.sv]
// types, constants and tables for the arc odometry pose update unit
`default_nettype none
package aopu_pkg;

    // cordic datapath width (q2.30 with headroom)
    localparam int CORDIC_W = 34;
    // divider widths
    localparam int NUM_W = 60;
    localparam int DEN_W = 38;
    localparam int REM_W = 72;
    localparam int QUO_W = 34;

    localparam logic [31:0] GAIN_Q30       = 32'd652032874;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic        [31:0] heading;
        logic signed [23:0] turn_rate;
        logic signed [23:0] forward_speed;
        logic        [15:0] time_step;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic        [31:0] new_heading;
        logic               saturated;
    } t_out_beat;

    // arctangent of 2^-i in binary angle units
    function automatic logic [31:0] atan_bam(input int idx);
        logic [31:0] res;
        unique case (idx)
            0:  res = 32'd536870912;
            1:  res = 32'd316933406;
            2:  res = 32'd167458907;
            3:  res = 32'd85004756;
            4:  res = 32'd42667331;
            5:  res = 32'd21354465;
            6:  res = 32'd10679838;
            7:  res = 32'd5340245;
            8:  res = 32'd2670163;
            9:  res = 32'd1335087;
            10: res = 32'd667544;
            11: res = 32'd333772;
            12: res = 32'd166886;
            13: res = 32'd83443;
            14: res = 32'd41722;
            15: res = 32'd20861;
            16: res = 32'd10430;
            17: res = 32'd5215;
            18: res = 32'd2608;
            19: res = 32'd1304;
            20: res = 32'd652;
            21: res = 32'd326;
            22: res = 32'd163;
            23: res = 32'd81;
            24: res = 32'd41;
            25: res = 32'd20;
            26: res = 32'd10;
            27: res = 32'd5;
            28: res = 32'd3;
            29: res = 32'd1;
            30: res = 32'd1;
            default: res = 32'd0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/aopu_dly.sv]
// enable-gated delay line carrying a valid bit and side data
`default_nettype none
module aopu_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_data [0:DEPTH-1];

    // valid bits shift with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DEPTH-2:0], i_valid};
        end
    end

    // data taps
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule
`default_nettype wire

[rtl/aopu_cordic.sv]
// pipelined rotation-mode cordic giving cosine and sine of a binary angle
`default_nettype none
module aopu_cordic import aopu_pkg::*; #(
    parameter int STAGES = 24
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [31:0]                i_angle,
    output logic signed [CORDIC_W-1:0] o_cos,
    output logic signed [CORDIC_W-1:0] o_sin
);

    logic signed [CORDIC_W-1:0] r_x [0:STAGES];
    logic signed [CORDIC_W-1:0] r_y [0:STAGES];
    logic signed [CORDIC_W-1:0] r_z [0:STAGES];
    logic        [1:0]          r_q [0:STAGES];
    logic signed [CORDIC_W-1:0] r_cos;
    logic signed [CORDIC_W-1:0] r_sin;

    logic [31:0] w_sum;
    logic [1:0]  w_quad;
    logic [31:0] w_res;

    // nearest quadrant and residual angle
    assign w_sum  = i_angle + 32'h2000_0000;
    assign w_quad = w_sum[31:30];
    assign w_res  = i_angle - {w_quad, 30'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= {{(CORDIC_W-32){1'b0}}, GAIN_Q30};
            r_y[0] <= '0;
            r_z[0] <= {{(CORDIC_W-32){w_res[31]}}, w_res};
            r_q[0] <= w_quad;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [CORDIC_W-1:0] w_atan;
        assign w_atan = {{(CORDIC_W-32){1'b0}}, atan_bam(i)};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][CORDIC_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - w_atan;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + w_atan;
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    // quadrant rotation of the result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_q[STAGES])
                2'd0: begin
                    r_cos <= r_x[STAGES];
                    r_sin <= r_y[STAGES];
                end
                2'd1: begin
                    r_cos <= -r_y[STAGES];
                    r_sin <= r_x[STAGES];
                end
                2'd2: begin
                    r_cos <= -r_x[STAGES];
                    r_sin <= -r_y[STAGES];
                end
                default: begin
                    r_cos <= r_y[STAGES];
                    r_sin <= -r_x[STAGES];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule
`default_nettype wire

[rtl/aopu_div.sv]
// pipelined restoring divider, unsigned, rounding to nearest
`default_nettype none
module aopu_div import aopu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    logic [REM_W-1:0] r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];

    // bias by half the divisor for round to nearest
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REM_W'(i_num) + REM_W'(i_den >> 1);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < QUO_W; j++) begin : g_bit
        localparam int K = QUO_W - 1 - j;
        logic [REM_W-1:0] w_shf;
        assign w_shf = REM_W'(r_den[j]) << K;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[j] >= w_shf) begin
                    r_rem[j+1] <= r_rem[j] - w_shf;
                    r_quo[j+1] <= r_quo[j] | (QUO_W'(1) << K);
                end else begin
                    r_rem[j+1] <= r_rem[j];
                    r_quo[j+1] <= r_quo[j];
                end
                r_den[j+1] <= r_den[j];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];

endmodule
`default_nettype wire

[rtl/arc_odometry_pose_update_unit.sv]
// arc odometry pose update unit, top level
// Pose update along a circular arc for a unicycle model, fixed point.
// Input channel i_in_valid / o_in_ready carries one t_in_beat: pose x, y
// (q16.16), heading (binary angle), turn rate and speed (q8.16) and time
// step (q0.16). Output channel o_out_valid / i_out_ready carries one
// t_out_beat per input beat: new pose, wrapped heading and a flag that is
// set when x or y was clamped to the 32-bit range.
// Latency is set by the cordic pipeline and the 35-stage radix-2 divider.
// Throughput is one beat per clock unless i_out_ready stalls the output;
// every stage is a register. The whole pipeline advances together: when
// the final beat waits for i_out_ready, every stage holds and o_in_ready
// drops, so nothing is lost or repeated. Reset clears all valid bits;
// payload is not reset. A zero turn rate, or a heading change that
// rounds to zero, gives straight-line motion.
`default_nettype none
`include "arc_odometry_pose_update_unit_assert.svh"
module arc_odometry_pose_update_unit import aopu_pkg::*; #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    localparam int DIV_LAT    = QUO_W + 1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [31:0] hn;
        logic signed [23:0] w;
        logic signed [23:0] v;
        logic               straight;
        logic signed [31:0] lxs;
    } t_side_a;

    typedef struct packed {
        logic signed [31:0]         x;
        logic signed [31:0]         y;
        logic        [31:0]         hn;
        logic                       straight;
        logic signed [31:0]         lxs;
        logic signed [CORDIC_W-1:0] ch;
        logic signed [CORDIC_W-1:0] sh;
    } t_side_b;

    typedef struct packed {
        t_side_b sb;
        logic    negx;
        logic    negy;
    } t_side_c;

    // global advance
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // stage 1: heading change and straight distance products
    logic               r1_valid;
    logic signed [39:0] r1_d;
    logic signed [39:0] r1_vdt;
    t_in_beat           r1_in;

    // stage 2: partial products of the angle scaling
    logic               r2_valid;
    logic        [49:0] r2_pl;
    logic signed [50:0] r2_ph;
    logic signed [31:0] r2_lxs;
    t_in_beat           r2_in;

    // stage 3: binary angle of the heading change
    logic               r3_valid;
    logic        [31:0] r3_dth;
    logic               r3_straight;
    logic signed [31:0] r3_lxs;
    t_in_beat           r3_in;

    logic [63:0] w_p;
    logic [31:0] w_dth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_in_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    assign w_p   = (64'(r2_ph) << 20) + 64'(r2_pl) + 64'h8000_0000;
    assign w_dth = w_p[63:32];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_d   <= i_in.turn_rate * $signed({1'b0, i_in.time_step});
            r1_vdt <= i_in.forward_speed * $signed({1'b0, i_in.time_step});
            r1_in  <= i_in;

            r2_pl  <= r1_d[19:0] * INV_TWO_PI_Q32[29:0];
            r2_ph  <= $signed(r1_d[39:20]) * $signed({1'b0, INV_TWO_PI_Q32[29:0]});
            r2_lxs <= 32'((r1_vdt + 40'sd32768) >>> 16);
            r2_in  <= r1_in;

            r3_dth      <= w_dth;
            r3_straight <= (w_dth == 32'd0);
            r3_lxs      <= r2_lxs;
            r3_in       <= r2_in;
        end
    end

    // cordic for the heading change and for the current heading
    logic signed [CORDIC_W-1:0] w_c;
    logic signed [CORDIC_W-1:0] w_s;
    logic signed [CORDIC_W-1:0] w_ch;
    logic signed [CORDIC_W-1:0] w_sh;

    aopu_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_dth (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r3_dth),
        .o_cos   (w_c),
        .o_sin   (w_s)
    );

    aopu_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_hdg (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r3_in.heading),
        .o_cos   (w_ch),
        .o_sin   (w_sh)
    );

    t_side_a w_sa_in;
    t_side_a w_sa_out;
    logic    w_sa_valid;

    assign w_sa_in.x        = r3_in.pose_x;
    assign w_sa_in.y        = r3_in.pose_y;
    assign w_sa_in.hn       = r3_in.heading + r3_dth;
    assign w_sa_in.w        = r3_in.turn_rate;
    assign w_sa_in.v        = r3_in.forward_speed;
    assign w_sa_in.straight = r3_straight;
    assign w_sa_in.lxs      = r3_lxs;

    aopu_dly #(.WIDTH($bits(t_side_a)), .DEPTH(CORDIC_LAT)) u_dly_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_valid),
        .i_data  (w_sa_in),
        .o_valid (w_sa_valid),
        .o_data  (w_sa_out)
    );

    // stage 4: arc numerators
    logic                    r4_valid;
    logic signed [NUM_W-1:0] r4_ns;
    logic signed [NUM_W-1:0] r4_nc;
    logic signed [23:0]      r4_w;
    t_side_b                 r4_sb;

    // stage 5: magnitudes and quotient signs
    logic                    r5_valid;
    logic        [NUM_W-1:0] r5_anx;
    logic        [NUM_W-1:0] r5_any;
    logic        [DEN_W-1:0] r5_den;
    logic                    r5_negx;
    logic                    r5_negy;
    t_side_b                 r5_sb;

    logic signed [CORDIC_W:0] w_omc;
    logic        [23:0]       w_aw;

    assign w_omc = 35'sh0_4000_0000 - w_c;
    assign w_aw  = r4_w[23] ? 24'(-r4_w) : 24'(r4_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= w_sa_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ns          <= $signed(w_sa_out.v) * w_s;
            r4_nc          <= $signed(w_sa_out.v) * w_omc;
            r4_w           <= w_sa_out.w;
            r4_sb.x        <= w_sa_out.x;
            r4_sb.y        <= w_sa_out.y;
            r4_sb.hn       <= w_sa_out.hn;
            r4_sb.straight <= w_sa_out.straight;
            r4_sb.lxs      <= w_sa_out.lxs;
            r4_sb.ch       <= w_ch;
            r4_sb.sh       <= w_sh;

            r5_anx  <= r4_ns[NUM_W-1] ? NUM_W'(-r4_ns) : NUM_W'(r4_ns);
            r5_any  <= r4_nc[NUM_W-1] ? NUM_W'(-r4_nc) : NUM_W'(r4_nc);
            r5_den  <= {w_aw, 14'd0};
            r5_negx <= r4_ns[NUM_W-1] ^ r4_w[23];
            r5_negy <= r4_nc[NUM_W-1] ^ r4_w[23];
            r5_sb   <= r4_sb;
        end
    end

    // arc displacement quotients
    logic [QUO_W-1:0] w_qx;
    logic [QUO_W-1:0] w_qy;

    aopu_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r5_anx),
        .i_den (r5_den),
        .o_quo (w_qx)
    );

    aopu_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r5_any),
        .i_den (r5_den),
        .o_quo (w_qy)
    );

    t_side_c w_sc_in;
    t_side_c w_sc_out;
    logic    w_sc_valid;

    assign w_sc_in.sb   = r5_sb;
    assign w_sc_in.negx = r5_negx;
    assign w_sc_in.negy = r5_negy;

    aopu_dly #(.WIDTH($bits(t_side_c)), .DEPTH(DIV_LAT)) u_dly_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_valid),
        .i_data  (w_sc_in),
        .o_valid (w_sc_valid),
        .o_data  (w_sc_out)
    );

    // signed quotient clamped to the 32-bit range
    function automatic logic [31:0] fix_quo(input logic [QUO_W-1:0] q, input logic neg);
        logic [31:0] res;
        if (!neg) begin
            res = (q > QUO_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            res = (q > QUO_W'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'd0 - q[31:0];
        end
        return res;
    endfunction

    // stage 6: local displacement
    logic                       r6_valid;
    logic signed [31:0]         r6_lx;
    logic signed [31:0]         r6_ly;
    logic signed [31:0]         r6_x;
    logic signed [31:0]         r6_y;
    logic        [31:0]         r6_hn;
    logic signed [CORDIC_W-1:0] r6_ch;
    logic signed [CORDIC_W-1:0] r6_sh;

    // stage 7: rotation products
    localparam int PW = CORDIC_W + 32;
    logic                 r7_valid;
    logic signed [PW-1:0] r7_p1;
    logic signed [PW-1:0] r7_p2;
    logic signed [PW-1:0] r7_p3;
    logic signed [PW-1:0] r7_p4;
    logic signed [31:0]   r7_x;
    logic signed [31:0]   r7_y;
    logic        [31:0]   r7_hn;

    // stage 8: world displacement
    localparam int GW = PW + 1 - 30;
    logic                 r8_valid;
    logic signed [GW-1:0] r8_gx;
    logic signed [GW-1:0] r8_gy;
    logic signed [31:0]   r8_x;
    logic signed [31:0]   r8_y;
    logic        [31:0]   r8_hn;

    // stage 9: output register
    logic      r9_valid;
    t_out_beat r9_out;

    logic signed [PW:0]   w_sx;
    logic signed [PW:0]   w_sy;
    logic signed [GW:0]   w_nx;
    logic signed [GW:0]   w_ny;
    logic signed [31:0]   w_cx;
    logic signed [31:0]   w_cy;
    logic                 w_satx;
    logic                 w_saty;

    assign w_sx = r7_p1 - r7_p2 + $signed((PW+1)'(1) << 29);
    assign w_sy = r7_p3 + r7_p4 + $signed((PW+1)'(1) << 29);
    assign w_nx = r8_x + r8_gx;
    assign w_ny = r8_y + r8_gy;

    // position saturation
    always_comb begin
        w_satx = 1'b1;
        w_saty = 1'b1;
        priority if (w_nx > $signed((GW+1)'(32'h7FFF_FFFF))) begin
            w_cx = 32'sh7FFF_FFFF;
        end else if (w_nx < -$signed((GW+1)'(33'h0_8000_0000))) begin
            w_cx = 32'sh8000_0000;
        end else begin
            w_cx   = w_nx[31:0];
            w_satx = 1'b0;
        end
        priority if (w_ny > $signed((GW+1)'(32'h7FFF_FFFF))) begin
            w_cy = 32'sh7FFF_FFFF;
        end else if (w_ny < -$signed((GW+1)'(33'h0_8000_0000))) begin
            w_cy = 32'sh8000_0000;
        end else begin
            w_cy   = w_ny[31:0];
            w_saty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
            r9_valid <= 1'b0;
        end else if (w_en) begin
            r6_valid <= w_sc_valid;
            r7_valid <= r6_valid;
            r8_valid <= r7_valid;
            r9_valid <= r8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_sc_out.sb.straight) begin
                r6_lx <= w_sc_out.sb.lxs;
                r6_ly <= '0;
            end else begin
                r6_lx <= fix_quo(w_qx, w_sc_out.negx);
                r6_ly <= fix_quo(w_qy, w_sc_out.negy);
            end
            r6_x  <= w_sc_out.sb.x;
            r6_y  <= w_sc_out.sb.y;
            r6_hn <= w_sc_out.sb.hn;
            r6_ch <= w_sc_out.sb.ch;
            r6_sh <= w_sc_out.sb.sh;

            r7_p1 <= r6_ch * r6_lx;
            r7_p2 <= r6_sh * r6_ly;
            r7_p3 <= r6_sh * r6_lx;
            r7_p4 <= r6_ch * r6_ly;
            r7_x  <= r6_x;
            r7_y  <= r6_y;
            r7_hn <= r6_hn;

            r8_gx <= GW'(w_sx >>> 30);
            r8_gy <= GW'(w_sy >>> 30);
            r8_x  <= r7_x;
            r8_y  <= r7_y;
            r8_hn <= r7_hn;

            r9_out.new_x       <= w_cx;
            r9_out.new_y       <= w_cy;
            r9_out.new_heading <= r8_hn;
            r9_out.saturated   <= w_satx | w_saty;
        end
    end

    assign o_out_valid = r9_valid;
    assign o_out       = r9_out;

    // a flagged beat carries a clamped coordinate
    `AOPU_ASSERT_IMP(a_sat_clamped, i_clk, i_rst_n, o_out_valid && o_out.saturated, o_out.new_x == 32'sh7FFF_FFFF || o_out.new_x == 32'sh8000_0000 || o_out.new_y == 32'sh7FFF_FFFF || o_out.new_y == 32'sh8000_0000)
    // zero turn rate always takes the straight path
    `AOPU_ASSERT_IMP(a_zero_rate_straight, i_clk, i_rst_n, r3_valid && r3_in.turn_rate == 24'sd0, r3_straight)
    // an accepted beat enters the first stage
    `AOPU_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && o_in_ready, r1_valid)
    // an empty output register never blocks the input
    `AOPU_ASSERT_IMP(a_no_false_stall, i_clk, i_rst_n, !o_out_valid, o_in_ready)

endmodule
`default_nettype wire

[dv/arc_odometry_pose_update_unit_test.sv]
// self-checking testbench for the arc odometry pose update unit
`timescale 1ns / 1ps
`default_nettype none
module arc_odometry_pose_update_unit_test;
    import aopu_pkg::*;

    localparam int STAGES = 24;

    // pose predictor and queue of expected output beats
    class pose_scoreboard;
        t_out_beat predicted_q[$];
        int        mismatches;
        int        results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // rotation-mode cordic with quadrant folding, q2.30 outputs
        static function void cordic_cos_sin(input logic [31:0] ang, output longint co,
                                            output longint si);
            logic [31:0] quad;
            logic [31:0] resid;
            longint      x, y, z, sx, sy;
            int          n;
            quad  = ((ang + 32'h2000_0000) >> 30) & 32'd3;
            resid = ang - (quad << 30);
            z     = longint'(signed'(resid));
            x     = longint'(GAIN_Q30);
            y     = 0;
            n     = (STAGES > 32) ? 32 : STAGES;
            for (int i = 0; i < n; i++) begin
                sx = y >>> i;
                sy = x >>> i;
                if (z >= 0) begin
                    x = x - sx; y = y + sy; z = z - longint'(atan_bam(i));
                end else begin
                    x = x + sx; y = y - sy; z = z + longint'(atan_bam(i));
                end
            end
            case (quad)
                0: begin co = x;  si = y;  end
                1: begin co = -y; si = x;  end
                2: begin co = -x; si = -y; end
                default: begin co = y; si = -x; end
            endcase
        endfunction

        // rounded division, ties away from zero
        static function longint div_nearest(input longint num, input longint den);
            logic [63:0] an, ad, q;
            an = (num < 0) ? 64'(-num) : 64'(num);
            ad = (den < 0) ? 64'(-den) : 64'(den);
            if (ad == 0) return 0;
            q = (an + ad / 2) / ad;
            return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
        endfunction

        static function longint clamp_i32(input longint v, inout bit hit);
            if (v > 64'sd2147483647) begin hit = 1; return 64'sd2147483647; end
            if (v < -64'sd2147483648) begin hit = 1; return -64'sd2147483648; end
            return v;
        endfunction

        // accepted input beat: predict its output beat
        function void note_input(input t_in_beat b);
            longint      px, py, w, v, dt, lx, ly, c, s, ch, sh, gx, gy, nx, ny;
            logic [63:0] prod;
            logic [31:0] dth;
            bit          sat, dummy;
            t_out_beat   r;
            px = b.pose_x; py = b.pose_y;
            w  = b.turn_rate; v = b.forward_speed;
            dt = longint'({16'd0, b.time_step});
            dth = 0; sat = 0; dummy = 0;
            if (w != 0) begin
                prod = 64'(w * dt) * 64'(INV_TWO_PI_Q32);
                dth  = 32'((prod + 64'h8000_0000) >> 32);
            end
            if (dth == 0) begin
                lx = (v * dt + 32768) >>> 16;
                ly = 0;
            end else begin
                cordic_cos_sin(dth, c, s);
                lx = div_nearest(v * s, w * 16384);
                ly = div_nearest(v * ((64'sd1 << 30) - c), w * 16384);
            end
            lx = clamp_i32(lx, dummy);
            ly = clamp_i32(ly, dummy);
            cordic_cos_sin(b.heading, ch, sh);
            gx = (ch * lx - sh * ly + (64'sd1 <<< 29)) >>> 30;
            gy = (sh * lx + ch * ly + (64'sd1 <<< 29)) >>> 30;
            nx = clamp_i32(px + gx, sat);
            ny = clamp_i32(py + gy, sat);
            r.new_x       = 32'(nx);
            r.new_y       = 32'(ny);
            r.new_heading = b.heading + dth;
            r.saturated   = sat;
            predicted_q.push_back(r);
        endfunction

        // accepted output beat: compare with the oldest prediction
        function void check_result(input t_out_beat got);
            t_out_beat exp_b;
            results_seen++;
            if (predicted_q.size() == 0) begin
                $display("%0t unexpected output beat actual %h", $realtime, got);
                mismatches++;
                return;
            end
            exp_b = predicted_q.pop_front();
            if (got.new_x !== exp_b.new_x) begin
                $display("%0t new_x expected %h actual %h", $realtime, exp_b.new_x, got.new_x);
                mismatches++;
            end
            if (got.new_y !== exp_b.new_y) begin
                $display("%0t new_y expected %h actual %h", $realtime, exp_b.new_y, got.new_y);
                mismatches++;
            end
            if (got.new_heading !== exp_b.new_heading) begin
                $display("%0t new_heading expected %h actual %h", $realtime,
                         exp_b.new_heading, got.new_heading);
                mismatches++;
            end
            if (got.saturated !== exp_b.saturated) begin
                $display("%0t saturated expected %b actual %b", $realtime,
                         exp_b.saturated, got.saturated);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out;

    pose_scoreboard sb = new();
    bit burst_mode = 0;

    arc_odometry_pose_update_unit #(.CORDIC_STAGES(STAGES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always #1 i_clk = ~i_clk;

    // beat monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_input(i_in);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);
    end

    // offer one input beat after a random gap (none in burst mode), wait for acceptance
    task automatic send_beat(input t_in_beat b);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic t_in_beat make_beat(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] h, input logic [23:0] w,
                                           input logic [23:0] v, input logic [15:0] dt);
        t_in_beat b;
        b.pose_x = x; b.pose_y = y; b.heading = h;
        b.turn_rate = w; b.forward_speed = v; b.time_step = dt;
        return b;
    endfunction

    // random beat: mostly full-range noise, some realistic motion and edge values
    function automatic t_in_beat random_beat();
        t_in_beat b;
        int sel;
        b   = make_beat($urandom, $urandom, $urandom, 24'($urandom), 24'($urandom),
                        16'($urandom));
        sel = $urandom_range(0, 9);
        case (sel)
            0: b.turn_rate = '0;
            1: b.turn_rate = 24'($urandom_range(0, 8)) - 24'd4;
            2: b.time_step = 16'($urandom_range(0, 16));
            3, 4: begin
                b.pose_x    = 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'h0080_0000);
                b.pose_y    = 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'h0080_0000);
                b.turn_rate = 24'($signed($urandom_range(0, 32'h3_ffff)) - 32'h2_0000);
            end
            5: b.pose_x = {1'b0, {31{b.pose_x[31]}}} ^ 32'($urandom_range(0, 3));
            default: ;
        endcase
        return b;
    endfunction

    // receiver: random stalls plus one long hold-off
    initial begin : receiver
        int gap;
        bit held;
        held = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && sb.results_seen >= 40 && burst_mode) begin
                held = 1;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        t_in_beat dir_q[$];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // straight line, zero time step, extremes, quadrants, tiny and huge arcs
        dir_q.push_back(make_beat(0, 0, 0, 0, 24'h01_0000, 16'hffff));
        dir_q.push_back(make_beat(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                  24'h7f_ffff, 24'h80_0000, 0));
        dir_q.push_back(make_beat(0, 0, 32'h4000_0000, 24'h7f_ffff, 24'h7f_ffff, 16'hffff));
        dir_q.push_back(make_beat(0, 0, 32'h8000_0000, 24'h80_0000, 24'h7f_ffff, 16'hffff));
        dir_q.push_back(make_beat(0, 0, 32'hc000_0000, 24'h80_0000, 24'h80_0000, 16'hffff));
        dir_q.push_back(make_beat(0, 0, 32'h2000_0000, 24'h01_0000, 24'h01_0000, 16'h8000));
        dir_q.push_back(make_beat(0, 0, 32'he000_0000, 24'hff_0000, 24'h01_0000, 16'h8000));
        dir_q.push_back(make_beat(0, 0, 0, 24'd1, 24'h7f_ffff, 16'd7));
        dir_q.push_back(make_beat(0, 0, 32'h1234_5678, 24'hff_ffff, 24'h80_0000, 16'd7));
        dir_q.push_back(make_beat(0, 0, 0, 24'd1, 24'h7f_ffff, 16'd3));
        dir_q.push_back(make_beat(32'h7fff_ff00, 0, 0, 0, 24'h7f_ffff, 16'hffff));
        dir_q.push_back(make_beat(32'h8000_0100, 0, 0, 0, 24'h80_0000, 16'hffff));
        dir_q.push_back(make_beat(0, 32'h7fff_ff00, 32'h4000_0000, 0, 24'h7f_ffff, 16'hffff));
        dir_q.push_back(make_beat(0, 32'h8000_0000, 32'hc000_0000, 24'd1, 24'h7f_ffff, 16'd7));
        dir_q.push_back(make_beat(32'h7fff_ffff, 32'h7fff_ffff, 32'h2000_0000, 24'd1,
                                  24'h7f_ffff, 16'd7));
        dir_q.push_back(make_beat(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 24'hff_ffff,
                                  24'hff_ffff, 16'hffff));
        foreach (dir_q[i]) send_beat(dir_q[i]);
        for (int n = 0; n < 400; n++) begin
            burst_mode = (n >= 60 && n < 200);
            if (n == 300) begin
                // sender pause until the pipeline has drained
                i_in_valid <= 1'b0;
                wait (sb.predicted_q.size() == 0);
                @(posedge i_clk);
            end
            send_beat(random_beat());
        end
        i_in_valid <= 1'b0;
        wait (sb.predicted_q.size() == 0);
        repeat (120) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.predicted_q.size() == 0)
            $display("arc_odometry_pose_update_unit verification clean");
        else
            $display("arc_odometry_pose_update_unit verification failed");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #2000000;
        $display("arc_odometry_pose_update_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/aopu_pkg.sv
rtl/aopu_dly.sv
rtl/aopu_cordic.sv
rtl/aopu_div.sv
rtl/arc_odometry_pose_update_unit.sv
dv/arc_odometry_pose_update_unit_test.sv
